/* design/srnr_pkg.sv */
// Shared types and constants for the selective-repeat NACK receiver.
// No dependencies; srnr_eval and the top level import this package.
package srnr_pkg;

   localparam int SEQ_DEPTH_DEF   = 4096;
   localparam int BUNDLE_SIZE_DEF = 32;
   localparam int MAX_NACKS_DEF   = 64;

   localparam int NOW_W   = 22;
   localparam int FULL_W  = 16;
   localparam int CNT_W   = 3;
   localparam int HI_W    = 17;
   localparam int S_W     = 17;
   localparam int K_W     = 8;
   localparam int N_W     = 7;
   localparam int FB_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic [15:0] PLAYOUT_RST = 16'd130;
   localparam logic [2:0]  MAXN_RST    = 3'd4;
   localparam logic [9:0]  SPACING_RST = 10'd30;
   localparam logic [7:0]  GAP_RST     = 8'd3;

   localparam logic [23:0] HEADROOM_MS = 24'd45;
   localparam logic [23:0] OLD_MS      = 24'd100;
   localparam logic [15:0] SCAN_LIMIT  = 16'hFFFF;

   typedef enum logic [1:0] {
      CSR_PLAYOUT = 2'd0,
      CSR_MAXN    = 2'd1,
      CSR_SPACING = 2'd2,
      CSR_GAP     = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CH_RD,
      ST_CH_WR,
      ST_SC_CHK,
      ST_SC_EV,
      ST_WK_CHK,
      ST_WK_EV,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic scan_skip;
      logic skip;
      logic cap_stop;
   } eval_type;

endpackage

/* design/srnr_ram.sv */
// Simple dual-port RAM with registered read, one write and one read port.
// Depends on nothing beyond its parameters.
module srnr_ram #(
   parameter int W = 4,
   parameter int D = 4096
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [$clog2(D)-1:0] waddr,
   input  logic [W-1:0]         wdata,
   input  logic                 re,
   input  logic [$clog2(D)-1:0] raddr,
   output logic [W-1:0]         rdata
);
   logic [W-1:0] mem [D];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule

/* design/srnr_eval.sv */
// Shared compare unit: judges one window entry per use (scan or NACK walk).
// Depends on srnr_pkg.
module srnr_eval import srnr_pkg::*; (
   input  logic [NOW_W-1:0] now,
   input  logic [15:0]      delay,
   input  logic [2:0]       max_nacks,
   input  logic [9:0]       spacing,
   input  logic [7:0]       gap,
   input  logic [S_W-1:0]   s,
   input  logic [HI_W-1:0]  hi,
   input  logic [FB_W-1:0]  fb,
   input  logic [K_W-1:0]   k,
   input  logic             dlv,
   input  logic [CNT_W-1:0] cnt,
   input  logic [NOW_W-1:0] last,
   output eval_type         res
);
   logic [23:0] s20, ddl, now24;
   logic        dead, old, gap_ok, spc_fail;
   logic [22:0] diff;
   logic [33:0] x;
   logic [41:0] p;

   always_comb begin
      now24  = 24'(now);
      s20    = (24'(s) << 4) + (24'(s) << 2);
      ddl    = 24'(delay) + s20;
      dead   = ddl < (now24 + HEADROOM_MS);
      old    = now24 > (s20 + OLD_MS);
      gap_ok = ($signed({2'b00, s}) + $signed({11'd0, gap}))
               <= $signed({{2{hi[HI_W-1]}}, hi});
      diff     = {1'b0, now} - {1'b0, last};
      spc_fail = (cnt != '0) && ($signed(diff) < $signed({13'd0, spacing}));
      // 1000*x > 32*now reduces to 125*x > 4*now
      x = 34'(fb) + 34'd4 + (34'(k) << 1);
      p = (42'(x) << 7) - (42'(x) << 1) - 42'(x);
      res.scan_skip = dlv || (ddl < now24);
      res.skip      = dlv || (cnt >= max_nacks) || dead || !(gap_ok || old) || spc_fail;
      res.cap_stop  = (now != '0) && (p > (42'(now) << 2));
   end
endmodule

/* design/selective_repeat_nack_receiver_top.sv */
// Top level of the selective-repeat NACK receiver: sequencer, state, RAMs.
// Depends on srnr_pkg, srnr_ram and srnr_eval.
//
// Channels: req_* carries one word per chunk (func 0, short_seq) or tick
// (func 1, now_ms). rsp_* returns result words: one decision per chunk, and
// zero to MAX_NACKS_PER_TICK NACK entries per tick. csr_* writes the four
// registers by index; it is always ready.
// Sequencing: a chunk reads its entry in ST_CH_RD; from ST_CH_WR its
// decision enters the output register as the block goes back to idle,
// waiting there while the output register is full. A tick advances the
// scan mark through ST_SC_CHK/ST_SC_EV past each delivered or expired
// entry, walks window entries through ST_WK_CHK/ST_WK_EV, and closes out
// in ST_FIN, with one registered read per step on the single RAM read port.
// Throughput: one word at a time; req_ready is high only in idle.
// Reset: after reset the block clears the delivered/count RAM, one entry a
// cycle, SEQ_DEPTH cycles, with req_ready low; registers return to their
// reset values at once and csr writes are taken throughout.
// Stall: a NACK entry is held until the next is taken or the tick ends,
// so its bundle/tick flags are known; with rsp_ready low and the output
// register full, the sequencer holds in place and resumes without loss.
module selective_repeat_nack_receiver_top import srnr_pkg::*; #(
   parameter int SEQ_DEPTH          = SEQ_DEPTH_DEF,
   parameter int BUNDLE_SIZE        = BUNDLE_SIZE_DEF,
   parameter int MAX_NACKS_PER_TICK = MAX_NACKS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  logic [7:0]           req_short_seq,
   input  logic [NOW_W-1:0]     req_now_ms,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_kind,
   output logic                 rsp_deliver,
   output logic [FULL_W-1:0]    rsp_full_seq,
   output logic [5:0]           rsp_bundle_count,
   output logic                 rsp_bundle_last,
   output logic                 rsp_tick_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);
   localparam int AW = $clog2(SEQ_DEPTH);
   localparam logic [17:0]    DEPTH_18 = 18'(SEQ_DEPTH);
   localparam logic [S_W-1:0] DEPTH_S  = S_W'(SEQ_DEPTH);
   localparam logic [K_W-1:0] BUNDLE_K = K_W'(BUNDLE_SIZE);
   localparam logic [N_W-1:0] MAXN_N   = N_W'(MAX_NACKS_PER_TICK);
   localparam logic [AW-1:0]  LAST_A   = AW'(SEQ_DEPTH - 1);

   state_type state_ff, state_in;

   // configuration registers
   logic [15:0] delay_ff;
   logic [2:0]  maxn_ff;
   logic [9:0]  spacing_ff;
   logic [7:0]  gap_ff;

   // block state
   logic [HI_W-1:0]   hi_ff, hi_in;
   logic [15:0]       scan_ff, scan_in;
   logic [FB_W-1:0]   fb_ff, fb_in;
   logic [AW-1:0]     clr_ff, clr_in;

   // per-item work registers
   logic [NOW_W-1:0]  now_ff, now_in;
   logic [17:0]       seq_ff, seq_in;
   logic [S_W-1:0]    s_ff, s_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [N_W-1:0]    n_ff, n_in;

   // held NACK entry, waiting for its flags
   logic              hv_ff, hv_in;
   logic [FULL_W-1:0] hseq_ff, hseq_in;
   logic [5:0]        hcnt_ff, hcnt_in;
   logic              hbl_ff, hbl_in;

   // output register
   logic              ov_ff, ov_in;
   logic              okind_ff, okind_in, odlv_ff, odlv_in, obl_ff, obl_in, otl_ff, otl_in;
   logic [FULL_W-1:0] oseq_ff, oseq_in;
   logic [5:0]        ocnt_ff, ocnt_in;

   // RAM ports
   logic          map_we, map_re, lt_we, lt_re;
   logic [AW-1:0] map_wa, map_ra, lt_wa;
   logic [3:0]    map_wd, map_rd;
   logic [NOW_W-1:0] lt_rd;

   eval_type ev;

   logic        free, inrange, fin_flush;
   logic [7:0]  delta;
   logic [17:0] uw;
   logic [K_W-1:0] k1;
   logic [32:0] bsum;

   srnr_ram #(.W(4), .D(SEQ_DEPTH)) u_map (
      .clock(clock), .we(map_we), .waddr(map_wa), .wdata(map_wd),
      .re(map_re), .raddr(map_ra), .rdata(map_rd)
   );

   srnr_ram #(.W(NOW_W), .D(SEQ_DEPTH)) u_last (
      .clock(clock), .we(lt_we), .waddr(lt_wa), .wdata(now_ff),
      .re(lt_re), .raddr(map_ra), .rdata(lt_rd)
   );

   srnr_eval u_eval (
      .now(now_ff), .delay(delay_ff), .max_nacks(maxn_ff), .spacing(spacing_ff),
      .gap(gap_ff), .s(s_ff), .hi(hi_ff), .fb(fb_ff), .k(k_ff),
      .dlv(map_rd[3]), .cnt(map_rd[2:0]), .last(lt_rd), .res(ev)
   );

   assign csr_ready        = 1'b1;
   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = ov_ff;
   assign rsp_kind         = okind_ff;
   assign rsp_deliver      = odlv_ff;
   assign rsp_full_seq     = oseq_ff;
   assign rsp_bundle_count = ocnt_ff;
   assign rsp_bundle_last  = obl_ff;
   assign rsp_tick_last    = otl_ff;

   // unwrap the one-byte number around the highest number seen
   assign delta   = req_short_seq - hi_ff[7:0];
   assign uw      = {hi_ff[HI_W-1], hi_ff} + {{10{delta[7]}}, delta};
   assign inrange = !seq_ff[17] && (seq_ff < DEPTH_18);
   assign free    = !ov_ff || rsp_ready;
   assign k1      = k_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      hi_in = hi_ff;  scan_in = scan_ff;  fb_in = fb_ff;  clr_in = clr_ff;
      now_in = now_ff;  seq_in = seq_ff;  s_in = s_ff;  k_in = k_ff;  n_in = n_ff;
      hv_in = hv_ff;  hseq_in = hseq_ff;  hcnt_in = hcnt_ff;  hbl_in = hbl_ff;
      ov_in = ov_ff && !rsp_ready;
      okind_in = okind_ff;  odlv_in = odlv_ff;  oseq_in = oseq_ff;
      ocnt_in = ocnt_ff;  obl_in = obl_ff;  otl_in = otl_ff;
      map_we = 1'b0;  map_wa = seq_ff[AW-1:0];  map_wd = '0;
      map_re = 1'b0;  map_ra = s_ff[AW-1:0];
      lt_we = 1'b0;  lt_wa = s_ff[AW-1:0];  lt_re = 1'b0;
      fin_flush = 1'b0;
      bsum = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            map_we = 1'b1;
            map_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_A) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               now_in = req_now_ms;
               seq_in = uw;
               state_in = req_func ? ST_SC_CHK : ST_CH_RD;
               k_in = '0;
               n_in = '0;
            end
         end
         ST_CH_RD: begin
            map_re = 1'b1;
            map_ra = seq_ff[AW-1:0];
            state_in = ST_CH_WR;
         end
         ST_CH_WR: begin
            if (free) begin
               ov_in = 1'b1;
               okind_in = 1'b0;
               ocnt_in = '0;  obl_in = 1'b0;  otl_in = 1'b0;
               if (inrange) begin
                  map_we = 1'b1;
                  map_wd = {1'b1, map_rd[2:0]};
                  odlv_in = !map_rd[3];
                  oseq_in = seq_ff[15:0];
                  if ($signed(seq_ff) > $signed({hi_ff[HI_W-1], hi_ff})) begin
                     hi_in = seq_ff[HI_W-1:0];
                  end
               end else begin
                  odlv_in = 1'b0;
                  oseq_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_SC_CHK: begin
            // advance the scan mark past delivered or expired entries
            s_in = S_W'(scan_ff);
            if (($signed({1'b0, scan_ff}) <= $signed(hi_ff)) && (scan_ff != SCAN_LIMIT)) begin
               map_re = 1'b1;
               map_ra = scan_ff[AW-1:0];
               state_in = ST_SC_EV;
            end else begin
               state_in = ST_WK_CHK;
            end
         end
         ST_SC_EV: begin
            if (ev.scan_skip) begin
               scan_in = scan_ff + 1'b1;
               state_in = ST_SC_CHK;
            end else begin
               state_in = ST_WK_CHK;
            end
         end
         ST_WK_CHK: begin
            if (($signed({1'b0, s_ff}) <= $signed({hi_ff[HI_W-1], hi_ff}))
                && (n_ff < MAXN_N) && (s_ff < DEPTH_S)) begin
               map_re = 1'b1;
               lt_re = 1'b1;
               state_in = ST_WK_EV;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_WK_EV: begin
            if (ev.skip) begin
               s_in = s_ff + 1'b1;
               state_in = ST_WK_CHK;
            end else if (ev.cap_stop) begin
               state_in = ST_FIN;
            end else if (!hv_ff || free) begin
               // push the previous entry out, hold this one
               if (hv_ff) begin
                  ov_in = 1'b1;  okind_in = 1'b1;  odlv_in = 1'b0;
                  oseq_in = hseq_ff;  ocnt_in = hcnt_ff;  obl_in = hbl_ff;  otl_in = 1'b0;
               end
               map_we = 1'b1;
               map_wa = s_ff[AW-1:0];
               map_wd = {1'b0, map_rd[2:0] + 1'b1};
               lt_we = 1'b1;
               hv_in = 1'b1;
               hseq_in = s_ff[15:0];
               hcnt_in = k1[5:0];
               hbl_in = (k1 == BUNDLE_K);
               n_in = n_ff + 1'b1;
               s_in = s_ff + 1'b1;
               if (k1 == BUNDLE_K) begin
                  bsum = 33'(fb_ff) + 33'd2 + (33'(k1) << 1);
                  fb_in = bsum[32] ? '1 : bsum[31:0];
                  k_in = '0;
               end else begin
                  k_in = k1;
               end
               state_in = ST_WK_CHK;
            end
         end
         ST_FIN: begin
            // close the open bundle once, then flush the held entry
            if (k_ff != '0) begin
               bsum = 33'(fb_ff) + 33'd2 + (33'(k_ff) << 1);
               fb_in = bsum[32] ? '1 : bsum[31:0];
               k_in = '0;
            end
            if (!hv_ff) begin
               state_in = ST_IDLE;
            end else if (free) begin
               fin_flush = 1'b1;
               ov_in = 1'b1;  okind_in = 1'b1;  odlv_in = 1'b0;
               oseq_in = hseq_ff;  ocnt_in = hcnt_ff;  obl_in = 1'b1;  otl_in = 1'b1;
               hv_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (fin_flush) begin
         hv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff   <= PLAYOUT_RST;
         maxn_ff    <= MAXN_RST;
         spacing_ff <= SPACING_RST;
         gap_ff     <= GAP_RST;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_PLAYOUT: delay_ff   <= csr_data;
            CSR_MAXN:    maxn_ff    <= csr_data[2:0];
            CSR_SPACING: spacing_ff <= csr_data[9:0];
            CSR_GAP:     gap_ff     <= csr_data[7:0];
            default:     delay_ff   <= delay_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_ff   <= '1;
         scan_ff <= '0;
         fb_ff   <= '0;
         clr_ff  <= '0;
         hv_ff   <= 1'b0;
         ov_ff   <= 1'b0;
         k_ff    <= '0;
         n_ff    <= '0;
      end else begin
         hi_ff   <= hi_in;
         scan_ff <= scan_in;
         fb_ff   <= fb_in;
         clr_ff  <= clr_in;
         hv_ff   <= hv_in;
         ov_ff   <= ov_in;
         k_ff    <= k_in;
         n_ff    <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff   <= now_in;
      seq_ff   <= seq_in;
      s_ff     <= s_in;
      hseq_ff  <= hseq_in;
      hcnt_ff  <= hcnt_in;
      hbl_ff   <= hbl_in;
      okind_ff <= okind_in;
      odlv_ff  <= odlv_in;
      oseq_ff  <= oseq_in;
      ocnt_ff  <= ocnt_in;
      obl_ff   <= obl_in;
      otl_ff   <= otl_in;
   end
endmodule
